// ===== sv/twe_pkg.sv =====
`default_nettype none
package twe_pkg;

  localparam int WIND_W     = 19;
  localparam int DIR_W      = 16;
  localparam int DIR_FRAC   = 14;
  localparam int VEL_IN_W   = 16;
  localparam int VEL_W      = 10;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam int WIND_MAX   = 262143;
  localparam int WIND_MIN   = -262144;

  // floor(x / 100) == (x * 5243) >> 19 for 0 <= x <= 32768.
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;

  // Smoothing: est = floor((19 est + w + 10) / 20), biased to stay positive.
  localparam int SMOOTH_KEEP = 19;
  localparam int SMOOTH_RND  = 10;
  localparam int SMOOTH_DIV  = 20;
  localparam int SMOOTH_OFF  = SMOOTH_DIV << WIND_W;
  localparam int SMOOTH_BIAS = 1 << WIND_W;

  // floor(x / 20) == (x * 26843546) >> 29 for 0 <= x < 2^26.
  localparam int RECIP_20       = 26843546;
  localparam int RECIP_20_SHIFT = 29;

  localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd10000;
  localparam logic [CFG_W-1:0] TURN_THR_RST = 16'd3277;
  localparam logic [CFG_W-1:0] MARGIN_RST = 16'd5120;

  typedef logic signed [WIND_W-1:0] wind_t;
  typedef logic signed [DIR_W-1:0] dir_t;
  typedef logic signed [VEL_W-1:0] vel_t;

  typedef enum logic [1:0] {
    OUT_REF_RESET = 2'd0,
    OUT_NO_TURN   = 2'd1,
    OUT_UPDATED   = 2'd2,
    OUT_REJECTED  = 2'd3
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT  = 2'd0,
    REG_TURN_THR = 2'd1,
    REG_MARGIN   = 2'd2
  } cfg_reg_t;

endpackage
`default_nettype wire

// ===== sv/turn_based_wind_estimator.sv =====
`default_nettype none
// Wind estimator driven by turns of the airframe.
// Input stream: one beat per GPS sample on s_tvalid/s_tready/s_tdata. The
// beat carries NED ground velocity in cm/s, the fuselage direction in Q2.14
// and a millisecond time stamp. Output stream: exactly one beat per input
// beat on m_tvalid/m_tready/m_tdata/m_tuser with the smoothed wind (Q.8 m/s)
// and an outcome code in m_tuser.
// Configuration writes (timeout, turn threshold, reject margin) go over the
// cfg_valid/cfg_ready port, which is always ready; write only while idle.
// Flow: one sample at a time. A timeout restart goes straight to the output,
// a sample without a turn stops after the squares, a rejected one after the
// wind check, and a full update also smooths the estimate. The work goes
// into four passes of a shared square-root unit, one pass of a divider and
// a shared multiplier for the squares and the airspeed products; smoothing
// registers the sum and then divides it by 20, one component at a time.
// s_tready is high only while the block waits for a new sample. A stalled
// receiver holds the finished beat in the output register; the next sample
// is accepted and processed meanwhile, and its result waits for that slot.
// Reset clears references, estimate and time, and sets the configuration
// registers to their defaults.
module turn_based_wind_estimator #(
  parameter int FRAC_BITS = 14
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // vel_north[15:0], vel_east[31:16], vel_down[47:32], dir_x[63:48],
  // dir_y[79:64], dir_z[95:80], now_ms[127:96]
  input  wire  [127:0] s_tdata,
  output logic         m_tvalid,
  input  wire          m_tready,
  // wind_north[18:0], wind_east[37:19], wind_down[56:38], zeros above
  output logic [63:0]  m_tdata,
  // outcome[1:0]
  output logic [1:0]   m_tuser,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [1:0]   cfg_index,
  input  wire  [15:0]  cfg_data
);

  localparam int SQ_IN_W = 2 * FRAC_BITS + 22;
  localparam int ROOT_W  = SQ_IN_W / 2;
  localparam int VAIR_W  = ROOT_W + twe_pkg::DIR_FRAC;
  localparam int DLEN_W  = 17;
  localparam int CH_W    = (VAIR_W + 1) / 2;
  localparam int MA_W    = (CH_W + 1 > twe_pkg::WIND_W) ? CH_W + 1 : twe_pkg::WIND_W;
  localparam int MB_W    = twe_pkg::WIND_W;
  localparam int P_W     = MA_W + MB_W;
  localparam int NUM_W   = VAIR_W + 19;
  localparam int ACC_W   = 38;
  localparam int DV2_W   = 22;
  localparam int LEN_W   = 19;
  localparam int SUM_W   = 17;
  localparam int VSUM_W  = 11;
  localparam int SM_W    = 26;
  localparam int SH_OUT  = FRAC_BITS + 7;
  localparam int SH_VSUM = FRAC_BITS + twe_pkg::DIR_FRAC;
  localparam int SH_RND  = FRAC_BITS + 6;

  localparam logic signed [NUM_W-1:0] WMAX_N = NUM_W'(twe_pkg::WIND_MAX);
  localparam logic signed [NUM_W-1:0] WMIN_N = NUM_W'(twe_pkg::WIND_MIN);

  localparam logic [1:0] PASS_A   = 2'd0;
  localparam logic [1:0] PASS_B   = 2'd1;
  localparam logic [1:0] PASS_THR = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_SQ_MUL, S_SQ_ACC, S_TURN, S_SQRT_D, S_SQRT_V, S_DIV_V,
    S_NUM_MUL, S_NUM_ACC, S_WIND, S_WSQ_MUL, S_WSQ_ACC, S_SQRT_W, S_SQRT_E,
    S_SM_DIV, S_OUT
  } state_t;

  state_t state;

  logic [twe_pkg::CFG_W-1:0] timeout_ms, turn_threshold, reject_margin;

  logic signed [twe_pkg::VEL_IN_W-1:0] raw [3];
  twe_pkg::dir_t   dir [3];
  twe_pkg::vel_t   vel [3];
  logic [31:0]     now;
  twe_pkg::vel_t   refv [3];
  twe_pkg::dir_t   refd [3];
  twe_pkg::wind_t  est [3];
  twe_pkg::wind_t  w [3];
  logic [31:0]     last_time;
  logic signed [NUM_W-1:0] num [3];

  logic [ACC_W-1:0]  acc_a, acc_b;
  logic [31:0]       thr2;
  logic [DLEN_W-1:0] dlen;
  logic [VAIR_W-1:0] vair;
  logic [LEN_W-1:0]  lw;
  logic [1:0]        idx, pass;
  logic              half;
  twe_pkg::outcome_t outcome;

  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [P_W-1:0]  p;

  logic               sq_start, sq_done, dv_start, dv_done;
  logic [SQ_IN_W-1:0] sq_x;
  logic [ROOT_W-1:0]  sq_root;
  logic [VAIR_W-1:0]  dv_n, dv_q;
  logic [DLEN_W-1:0]  dv_d;

  logic [16:0]            mag [3];
  logic [29:0]            prod [3];
  twe_pkg::vel_t          vel_c [3];
  logic signed [SUM_W-1:0]  dd [3], dsum [3];
  logic signed [VSUM_W-1:0] dv [3], vsum [3];
  twe_pkg::wind_t         w_c [3];
  logic signed [SM_W-1:0] sm_c;
  logic [23:0]            sm_r;
  logic [48:0]            sm_prod;
  logic signed [20:0]     qs;
  logic [31:0]            elapsed;
  logic signed [NUM_W-1:0] p_ext;

  function automatic twe_pkg::wind_t sat_wind(input logic signed [NUM_W-1:0] v);
    if (v > WMAX_N) return twe_pkg::wind_t'(twe_pkg::WIND_MAX);
    if (v < WMIN_N) return twe_pkg::wind_t'(twe_pkg::WIND_MIN);
    return v[twe_pkg::WIND_W-1:0];
  endfunction

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // Truncation toward zero: divide the magnitude, then restore the sign.
      mag[i]   = raw[i][15] ? 17'(-17'(raw[i])) : 17'(raw[i]);
      prod[i]  = 30'(mag[i]) * 30'(twe_pkg::RECIP_100);
      vel_c[i] = raw[i][15] ? 10'(-prod[i][29:twe_pkg::RECIP_SHIFT])
                            : 10'(prod[i][29:twe_pkg::RECIP_SHIFT]);
      dd[i]    = SUM_W'(dir[i]) - SUM_W'(refd[i]);
      dsum[i]  = SUM_W'(dir[i]) + SUM_W'(refd[i]);
      dv[i]    = VSUM_W'(vel[i]) - VSUM_W'(refv[i]);
      vsum[i]  = VSUM_W'(vel[i]) + VSUM_W'(refv[i]);
      w_c[i]   = sat_wind(num[i] >>> SH_OUT);
    end
  end

  assign elapsed = now - last_time;
  assign p_ext   = NUM_W'(p);
  assign sm_c    = SM_W'(est[idx]) * SM_W'(twe_pkg::SMOOTH_KEEP) + SM_W'(w[idx])
                 + SM_W'(twe_pkg::SMOOTH_RND) + SM_W'(twe_pkg::SMOOTH_OFF);
  // The biased smoothing sum is positive and below 2^24.
  assign sm_prod = 49'(sm_r) * 49'(twe_pkg::RECIP_20);
  assign qs      = 21'($signed({1'b0, sm_prod[48:twe_pkg::RECIP_20_SHIFT]}))
                 - 21'(twe_pkg::SMOOTH_BIAS);

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_SQ_MUL: begin
        case (pass)
          PASS_A: begin
            ma = MA_W'(dd[idx]);
            mb = MB_W'(dd[idx]);
          end
          PASS_B: begin
            ma = MA_W'(dv[idx]);
            mb = MB_W'(dv[idx]);
          end
          default: begin
            ma = MA_W'({1'b0, turn_threshold});
            mb = MB_W'({1'b0, turn_threshold});
          end
        endcase
      end
      S_NUM_MUL: begin
        // Airspeed is split in two halves, high half first.
        ma = half ? MA_W'(vair[CH_W-1:0]) : MA_W'(vair[VAIR_W-1:CH_W]);
        mb = MB_W'(dsum[idx]);
      end
      S_WSQ_MUL: begin
        if (pass == PASS_A) begin
          ma = MA_W'(w[idx]);
          mb = MB_W'(w[idx]);
        end else begin
          ma = MA_W'(est[idx]);
          mb = MB_W'(est[idx]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
  end

  always_comb begin
    case (state)
      S_SQRT_D, S_SQRT_W: sq_x = SQ_IN_W'(acc_a);
      S_SQRT_V:           sq_x = {acc_b[DV2_W-1:0], {(2 * FRAC_BITS){1'b0}}};
      default:            sq_x = SQ_IN_W'(acc_b);
    endcase
  end

  assign dv_n = {sq_root, {twe_pkg::DIR_FRAC{1'b0}}};
  assign dv_d = dlen;

  twe_isqrt #(.IN_W(SQ_IN_W)) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  twe_div #(.N_W(VAIR_W), .D_W(DLEN_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_n),
    .divisor  (dv_d),
    .done     (dv_done),
    .quotient (dv_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_tvalid       <= 1'b0;
      sq_start       <= 1'b0;
      dv_start       <= 1'b0;
      timeout_ms     <= twe_pkg::TIMEOUT_RST;
      turn_threshold <= twe_pkg::TURN_THR_RST;
      reject_margin  <= twe_pkg::MARGIN_RST;
      last_time      <= '0;
      idx            <= '0;
      pass           <= PASS_A;
      half           <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        refv[i] <= '0;
        refd[i] <= '0;
        est[i]  <= '0;
      end
    end else begin
      sq_start <= 1'b0;
      dv_start <= 1'b0;

      if (cfg_valid) begin
        unique case (twe_pkg::cfg_reg_t'(cfg_index))
          twe_pkg::REG_TIMEOUT:  timeout_ms     <= cfg_data;
          twe_pkg::REG_TURN_THR: turn_threshold <= cfg_data;
          twe_pkg::REG_MARGIN:   reject_margin  <= cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            raw[0] <= s_tdata[15:0];
            raw[1] <= s_tdata[31:16];
            raw[2] <= s_tdata[47:32];
            dir[0] <= s_tdata[63:48];
            dir[1] <= s_tdata[79:64];
            dir[2] <= s_tdata[95:80];
            now    <= s_tdata[127:96];
            state  <= S_PREP;
          end
        end
        S_PREP: begin
          for (int i = 0; i < 3; i++) vel[i] <= vel_c[i];
          acc_a <= '0;
          acc_b <= '0;
          idx   <= '0;
          pass  <= PASS_A;
          if (elapsed > 32'(timeout_ms)) begin
            for (int i = 0; i < 3; i++) begin
              refv[i] <= vel_c[i];
              refd[i] <= dir[i];
            end
            last_time <= now;
            outcome   <= twe_pkg::OUT_REF_RESET;
            state     <= S_OUT;
          end else begin
            state <= S_SQ_MUL;
          end
        end
        S_SQ_MUL: state <= S_SQ_ACC;
        S_SQ_ACC: begin
          case (pass)
            PASS_A:  acc_a <= acc_a + p[ACC_W-1:0];
            PASS_B:  acc_b <= acc_b + p[ACC_W-1:0];
            default: thr2  <= p[31:0];
          endcase
          if (pass == PASS_THR) begin
            state <= S_TURN;
          end else if (idx == 2'd2) begin
            idx   <= '0;
            pass  <= pass + 1'b1;
            state <= S_SQ_MUL;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SQ_MUL;
          end
        end
        S_TURN: begin
          if (acc_a > ACC_W'(thr2)) begin
            sq_start <= 1'b1;
            state    <= S_SQRT_D;
          end else begin
            outcome <= twe_pkg::OUT_NO_TURN;
            state   <= S_OUT;
          end
        end
        S_SQRT_D: begin
          if (sq_done) begin
            dlen     <= sq_root[DLEN_W-1:0];
            sq_start <= 1'b1;
            state    <= S_SQRT_V;
          end
        end
        S_SQRT_V: begin
          if (sq_done) begin
            dv_start <= 1'b1;
            state    <= S_DIV_V;
          end
        end
        S_DIV_V: begin
          if (dv_done) begin
            vair <= dv_q;
            for (int i = 0; i < 3; i++) begin
              num[i] <= (NUM_W'(vsum[i]) <<< SH_VSUM) + (NUM_W'(1) << SH_RND);
            end
            idx   <= '0;
            half  <= 1'b0;
            state <= S_NUM_MUL;
          end
        end
        S_NUM_MUL: state <= S_NUM_ACC;
        S_NUM_ACC: begin
          if (!half) begin
            num[idx] <= num[idx] - (p_ext <<< CH_W);
            half     <= 1'b1;
            state    <= S_NUM_MUL;
          end else begin
            num[idx] <= num[idx] - p_ext;
            half     <= 1'b0;
            if (idx == 2'd2) begin
              state <= S_WIND;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_NUM_MUL;
            end
          end
        end
        S_WIND: begin
          for (int i = 0; i < 3; i++) begin
            w[i]    <= w_c[i];
            refv[i] <= vel[i];
            refd[i] <= dir[i];
          end
          last_time <= now;
          acc_a     <= '0;
          acc_b     <= '0;
          idx       <= '0;
          pass      <= PASS_A;
          state     <= S_WSQ_MUL;
        end
        S_WSQ_MUL: state <= S_WSQ_ACC;
        S_WSQ_ACC: begin
          if (pass == PASS_A) acc_a <= acc_a + p[ACC_W-1:0];
          else                acc_b <= acc_b + p[ACC_W-1:0];
          if (idx == 2'd2) begin
            idx <= '0;
            if (pass == PASS_A) begin
              pass  <= PASS_B;
              state <= S_WSQ_MUL;
            end else begin
              sq_start <= 1'b1;
              state    <= S_SQRT_W;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_WSQ_MUL;
          end
        end
        S_SQRT_W: begin
          if (sq_done) begin
            lw       <= sq_root[LEN_W-1:0];
            sq_start <= 1'b1;
            state    <= S_SQRT_E;
          end
        end
        S_SQRT_E: begin
          if (sq_done) begin
            if (20'(lw) < 20'(sq_root[LEN_W-1:0]) + 20'(reject_margin)) begin
              idx     <= '0;
              half    <= 1'b0;
              outcome <= twe_pkg::OUT_UPDATED;
              state   <= S_SM_DIV;
            end else begin
              outcome <= twe_pkg::OUT_REJECTED;
              state   <= S_OUT;
            end
          end
        end
        S_SM_DIV: begin
          // The sum is registered first, then divided by 20.
          if (!half) begin
            sm_r <= 24'($unsigned(sm_c));
            half <= 1'b1;
          end else begin
            est[idx] <= sat_wind(NUM_W'(qs));
            half     <= 1'b0;
            if (idx == 2'd2) begin
              state <= S_OUT;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'b0, est[2], est[1], est[0]};
            m_tuser  <= outcome;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/twe_isqrt.sv =====
`default_nettype none
module twe_isqrt #(
  parameter int IN_W = 50
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire  [IN_W-1:0]     x,
  output logic                done,
  output logic [IN_W/2-1:0]   root
);

  localparam int RW = IN_W / 2;
  localparam int CW = $clog2(RW + 1);

  logic [IN_W-1:0] xs;
  logic [RW:0]     rem;
  logic [CW-1:0]   cnt;
  logic            run;
  logic [RW+2:0]   rem_sh;
  logic [RW+2:0]   trial;

  // One result bit per cycle: bring down two radicand bits, try 4*root+1.
  assign rem_sh = {rem, xs[IN_W-1:IN_W-2]};
  assign trial  = (RW + 3)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xs   <= x;
        rem  <= '0;
        root <= '0;
        cnt  <= CW'(RW);
        run  <= 1'b1;
      end else if (run) begin
        xs <= xs << 2;
        if (rem_sh >= trial) begin
          rem  <= (RW + 1)'(rem_sh - trial);
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[RW:0];
          root <= {root[RW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/twe_div.sv =====
`default_nettype none
module twe_div #(
  parameter int N_W = 39,
  parameter int D_W = 17
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  wire  [N_W-1:0]   dividend,
  input  wire  [D_W-1:0]   divisor,
  output logic             done,
  output logic [N_W-1:0]   quotient
);

  localparam int CW = $clog2(N_W + 1);

  logic [D_W-1:0] r;
  logic [D_W-1:0] d;
  logic [CW-1:0]  cnt;
  logic           run;
  logic [D_W:0]   r_sh;

  // Restoring division, one quotient bit per cycle; the dividend shifts out
  // of the top of the quotient register as quotient bits shift in.
  assign r_sh = {r, quotient[N_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        d        <= divisor;
        r        <= '0;
        cnt      <= CW'(N_W);
        run      <= 1'b1;
      end else if (run) begin
        if (r_sh >= {1'b0, d}) begin
          r        <= D_W'(r_sh - {1'b0, d});
          quotient <= {quotient[N_W-2:0], 1'b1};
        end else begin
          r        <= r_sh[D_W-1:0];
          quotient <= {quotient[N_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb_turn_based_wind_estimator.sv =====
`timescale 1ns / 100ps
module tb_turn_based_wind_estimator;

  typedef struct packed {
    logic signed [15:0] vn, ve, vd;
    logic signed [15:0] dx, dy, dz;
    logic [31:0] now;
  } sample_t;

  typedef struct packed {
    logic signed [18:0] wn, we, wd;
    logic [1:0] oc;
  } wind_beat_t;

  // Index with no register behind it.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [127:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  turn_based_wind_estimator i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [15:0] p_timeout, p_thr, p_margin;
  int p_refv[3], p_refd[3], p_est[3];
  logic [31:0] p_last;
  wind_beat_t wind_q[$];
  int errors = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_cycles = 0;
  int ms_now = 0;

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int sat_wind(longint v);
    if (v > twe_pkg::WIND_MAX) return twe_pkg::WIND_MAX;
    if (v < twe_pkg::WIND_MIN) return twe_pkg::WIND_MIN;
    return int'(v);
  endfunction

  task automatic predict_wind(input sample_t s);
    int vel[3], dir[3], w[3];
    longint unsigned dd2, dv2, dlen, vlen, w2, e2;
    longint vair, num, q, dd, dv;
    logic [31:0] dt;
    wind_beat_t r;
    vel[0] = int'(s.vn) / 100;
    vel[1] = int'(s.ve) / 100;
    vel[2] = int'(s.vd) / 100;
    dir[0] = int'(s.dx);
    dir[1] = int'(s.dy);
    dir[2] = int'(s.dz);
    dt = s.now - p_last;
    if (dt > {16'd0, p_timeout}) begin
      p_last = s.now;
      for (int i = 0; i < 3; i++) begin
        p_refv[i] = vel[i];
        p_refd[i] = dir[i];
      end
      r.oc = twe_pkg::OUT_REF_RESET;
    end else begin
      dd2 = 0;
      dv2 = 0;
      for (int i = 0; i < 3; i++) begin
        dd = longint'(dir[i] - p_refd[i]);
        dv = longint'(vel[i] - p_refv[i]);
        dd2 += 64'(dd * dd);
        dv2 += 64'(dv * dv);
      end
      if (dd2 <= 64'(longint'(p_thr) * longint'(p_thr))) begin
        r.oc = twe_pkg::OUT_NO_TURN;
      end else begin
        dlen = isqrt(dd2);
        vlen = isqrt(dv2 << 28);
        vair = longint'((vlen << 14) / dlen);
        for (int i = 0; i < 3; i++) begin
          num = longint'(vel[i] + p_refv[i]) * (64'sd1 <<< 28)
              - vair * longint'(dir[i] + p_refd[i]) + (64'sd1 <<< 20);
          w[i] = sat_wind(num >>> 21);
          p_refv[i] = vel[i];
          p_refd[i] = dir[i];
        end
        w2 = 0;
        e2 = 0;
        for (int i = 0; i < 3; i++) begin
          w2 += 64'(longint'(w[i]) * w[i]);
          e2 += 64'(longint'(p_est[i]) * p_est[i]);
        end
        if (isqrt(w2) < isqrt(e2) + 64'(p_margin)) begin
          for (int i = 0; i < 3; i++) begin
            num = 19 * longint'(p_est[i]) + w[i] + 10;
            q = (num + (64'sd20 <<< 19)) / 20 - (64'sd1 <<< 19);
            p_est[i] = sat_wind(q);
          end
          r.oc = twe_pkg::OUT_UPDATED;
        end else begin
          r.oc = twe_pkg::OUT_REJECTED;
        end
        p_last = s.now;
      end
    end
    r.wn = 19'(p_est[0]);
    r.we = 19'(p_est[1]);
    r.wd = 19'(p_est[2]);
    wind_q.push_back(r);
  endtask

  task automatic send_sample(input sample_t s);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    s_tdata <= {s.now, s.dz, s.dy, s.dx, s.vd, s.ve, s.vn};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_wind(s);
    @(negedge clk);
    s_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      twe_pkg::REG_TIMEOUT: p_timeout = val;
      twe_pkg::REG_TURN_THR: p_thr = val;
      twe_pkg::REG_MARGIN: p_margin = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while (wind_q.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (400) @(negedge clk);
  endtask

  // Random sample; direction components mostly within +-1.0, sometimes wild.
  function automatic sample_t rand_sample();
    sample_t s;
    s.vn = 16'($urandom);
    s.ve = 16'($urandom);
    s.vd = 16'($urandom);
    if ($urandom_range(9) == 0) begin
      s.vn = 16'($urandom_range(3000) - 1500);
      s.ve = 16'($urandom_range(3000) - 1500);
      s.vd = 16'($urandom_range(600) - 300);
    end
    if ($urandom_range(9) < 8) begin
      s.dx = 16'($urandom_range(32768) - 16384);
      s.dy = 16'($urandom_range(32768) - 16384);
      s.dz = 16'($urandom_range(8000) - 4000);
    end else begin
      s.dx = 16'($urandom);
      s.dy = 16'($urandom);
      s.dz = 16'($urandom);
    end
    ms_now += ($urandom_range(9) == 0) ? int'($urandom_range(70000))
                                       : int'($urandom_range(300));
    s.now = ($urandom_range(49) == 0) ? 32'($urandom) : 32'(ms_now);
    return s;
  endfunction

  task automatic run_random(input int n);
    repeat (n) send_sample(rand_sample());
  endtask

  task automatic test_directed;
    sample_t s;
    s = '{default: '0};
    s.now = 32'd5;
    send_sample(s);                               // zero references, no turn
    s.now = 32'd20000;
    s.dx = 16'sd16384;
    send_sample(s);                               // timeout restart
    s.now = 32'd20100;
    s.dx = -16'sd16384;
    s.vn = 16'sd32767;
    send_sample(s);                               // turn
    s.dx = 16'sh7fff;
    s.dy = 16'sh8000;
    s.dz = 16'sh8000;
    s.vn = 16'sh8000;
    s.ve = 16'sh8000;
    s.vd = 16'sh7fff;
    s.now = 32'd20200;
    send_sample(s);                               // out of range direction, big sample
    s.now = 32'hffff_fff0;
    send_sample(s);                               // restart near wrap
    s.now = 32'h0000_0010;
    s.dx = 16'sd16384;
    s.dy = 16'sd0;
    s.dz = 16'sd0;
    s.vn = -16'sd199;
    s.ve = 16'sd199;
    s.vd = -16'sd99;
    send_sample(s);                               // time wraps, turn
    s.now = 32'h0000_0020;
    s.dx = 16'sd16384;
    send_sample(s);                               // no turn
    for (int i = 0; i < 14; i++) send_sample(rand_sample());
    drain();
  endtask

  task automatic test_config_sweep;
    write_reg(twe_pkg::REG_TIMEOUT, 16'hffff);
    write_reg(twe_pkg::REG_TURN_THR, 16'd0);
    write_reg(twe_pkg::REG_MARGIN, 16'hffff);
    run_random(100);
    drain();
    write_reg(twe_pkg::REG_TIMEOUT, 16'd0);
    write_reg(twe_pkg::REG_TURN_THR, 16'd32768);
    write_reg(twe_pkg::REG_MARGIN, 16'd0);
    run_random(40);
    drain();
    write_reg(twe_pkg::REG_TIMEOUT, 16'd10000);
    write_reg(twe_pkg::REG_TURN_THR, 16'd3277);
    write_reg(twe_pkg::REG_MARGIN, 16'd5120);
    write_reg(REG_UNUSED, 16'hffff);
  endtask

  task automatic test_idle_phases;
    send_idle_pct = 82;
    run_random(150);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 82;
    run_random(150);
    drain();
    send_idle_pct = 21;
    recv_stall_pct = 21;
    write_reg(twe_pkg::REG_MARGIN, 16'd300);
    run_random(150);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(twe_pkg::REG_MARGIN, 16'd5120);
    run_random(150);
    drain();
  endtask

  task automatic test_backpressure;
    hold_cycles = 3000;
    run_random(10);
    drain();
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    wind_beat_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (wind_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        exp_r = wind_q.pop_front();
        if (m_tdata[18:0] !== exp_r.wn) begin
          $error("wind_north expected %0d got %0d", exp_r.wn, $signed(m_tdata[18:0]));
          errors++;
        end
        if (m_tdata[37:19] !== exp_r.we) begin
          $error("wind_east expected %0d got %0d", exp_r.we, $signed(m_tdata[37:19]));
          errors++;
        end
        if (m_tdata[56:38] !== exp_r.wd) begin
          $error("wind_down expected %0d got %0d", exp_r.wd, $signed(m_tdata[56:38]));
          errors++;
        end
        if (m_tuser !== exp_r.oc) begin
          $error("outcome expected %0d got %0d", exp_r.oc, m_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    p_timeout = twe_pkg::TIMEOUT_RST;
    p_thr = twe_pkg::TURN_THR_RST;
    p_margin = twe_pkg::MARGIN_RST;
    p_last = '0;
    for (int i = 0; i < 3; i++) begin
      p_refv[i] = 0;
      p_refd[i] = 0;
      p_est[i] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_config_sweep();
    test_idle_phases();
    test_backpressure();
    if (wind_q.size() != 0) begin
      $error("%0d expected results never arrived", wind_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("turn_based_wind_estimator test passed");
    end else begin
      $display("turn_based_wind_estimator test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("turn_based_wind_estimator test failed");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/twe_pkg.sv
sv/twe_isqrt.sv
sv/twe_div.sv
sv/turn_based_wind_estimator.sv
sim/tb_turn_based_wind_estimator.sv
